[design/e2q_pkg.sv]
// ---------------------------------------------------------------------------
// e2q_pkg: shared constants and types of the Euler-to-quaternion block
// Fixed-point formats, the Q1.30 rounding product and the reciprocal-multiply division.
// ---------------------------------------------------------------------------
package e2q_pkg;

	localparam int ANGLE_BITS     = 16;
	localparam int QUAT_FRAC_BITS = 14;
	localparam int QUAT_BITS      = QUAT_FRAC_BITS + 2;
	localparam int WORK_FRAC      = 30;
	localparam int SERIES_TERMS   = 6;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic signed [32:0] WORK_ONE = 33'sd1 <<< WORK_FRAC;

	// Q1.30 magnitudes fit in 31 bits; signed working values use 33 bits.
	typedef logic signed [32:0] work_t;

	typedef struct packed {
		work_t s;
		work_t c;
	} sincos_t;

	// Signed Q1.30 product, rounded to nearest with ties away from zero.
	function automatic work_t qmul(input work_t a, input work_t b);
		logic        neg;
		logic [31:0] ua;
		logic [31:0] ub;
		logic [63:0] p;
		logic [63:0] r;
		begin
			neg = a[32] ^ b[32];
			ua  = a[32] ? 32'(-a) : 32'(a);
			ub  = b[32] ? 32'(-b) : 32'(b);
			p   = ua * ub;
			r   = (p + (64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC;
			qmul = neg ? -work_t'(r[32:0]) : work_t'(r[32:0]);
		end
	endfunction

	// Truncating division by a constant d, given m = ceil(2^sh / d) with
	// sh = 32 + clog2(d); the quotient is exact for magnitudes below 2^32.
	function automatic work_t mul_recip(input work_t v, input logic [32:0] m,
		input int sh);
		logic [31:0] mag;
		logic [64:0] p;
		logic [31:0] q;
		begin
			mag = v[32] ? 32'(-v) : 32'(v);
			p   = {33'd0, mag} * {32'd0, m};
			q   = 32'(p >> sh);
			mul_recip = v[32] ? -work_t'({1'b0, q}) : work_t'({1'b0, q});
		end
	endfunction

	function automatic work_t clamp_unit(input work_t v);
		begin
			if (v < 0)
				clamp_unit = '0;
			else if (v > WORK_ONE)
				clamp_unit = WORK_ONE;
			else
				clamp_unit = v;
		end
	endfunction

	// Q1.30 to the output format: round half away from zero, saturate to +-1.0.
	function automatic logic signed [QUAT_BITS-1:0] to_output(input work_t v);
		localparam int SH = WORK_FRAC - QUAT_FRAC_BITS;
		logic        neg;
		logic [32:0] mag;
		logic [32:0] r;
		begin
			neg = v[32];
			mag = neg ? 33'(-v) : 33'(v);
			r   = (mag + (33'd1 << (SH - 1))) >> SH;
			if (r > (33'd1 << QUAT_FRAC_BITS))
				r = 33'd1 << QUAT_FRAC_BITS;
			to_output = neg ? QUAT_BITS'(-r) : QUAT_BITS'(r);
		end
	endfunction

endpackage

[design/e2q_sincos.sv]
// ---------------------------------------------------------------------------
// e2q_sincos: pipelined half-angle sine and cosine
// Scales the binary angle to radians, then runs each Horner step over a
// product stage and a reciprocal-multiply division stage.
// ---------------------------------------------------------------------------
module e2q_sincos (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [e2q_pkg::ANGLE_BITS-1:0] angle,
	output e2q_pkg::sincos_t                    sc
);
	import e2q_pkg::*;

	localparam int NST = 2 * SERIES_TERMS + 2;
	localparam logic [ANGLE_BITS-1:0] TOP = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

	// Stage 0: theta.  Stage 1: x2.  Then two stages per Horner step (product,
	// division).  Last stage: output.  Fifteen stages in all.
	logic [ANGLE_BITS-1:0] mag;
	logic [ANGLE_BITS+31:0] th_full;
	work_t theta_s1;
	logic  neg_s1;
	work_t theta_p [NST-1];
	logic  neg_p   [NST];
	work_t x2_p    [NST-3];
	work_t rs_p    [NST];
	work_t rc_p    [NST];
	work_t rs_div  [SERIES_TERMS];
	work_t rc_div  [SERIES_TERMS];

	assign mag = angle[ANGLE_BITS-1] ? ANGLE_BITS'(-angle) : angle;
	always_comb begin
		th_full = {32'd0, mag} * {{ANGLE_BITS{1'b0}}, HALF_PI_Q30};
		th_full = (th_full + (ANGLE_BITS+32)'(TOP >> 1)) >> (ANGLE_BITS - 1);
	end

	// Each series divisor is a constant, so its quotient comes from a
	// multiplication by the rounded-up reciprocal.
	for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_div
		localparam int N   = SERIES_TERMS - k + 1;
		localparam int DS  = (2 * N) * (2 * N + 1);
		localparam int DC  = (2 * N - 1) * (2 * N);
		localparam int SHS = 32 + $clog2(DS);
		localparam int SHC = 32 + $clog2(DC);
		localparam logic [32:0] MS = 33'(((64'd1 << SHS) + 64'(DS - 1)) / 64'(DS));
		localparam logic [32:0] MC = 33'(((64'd1 << SHC) + 64'(DC - 1)) / 64'(DC));

		assign rs_div[k-1] = WORK_ONE - mul_recip(rs_p[2*k-1], MS, SHS);
		assign rc_div[k-1] = WORK_ONE - mul_recip(rc_p[2*k-1], MC, SHC);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			theta_s1 <= work_t'(th_full[32:0]);
			neg_s1   <= angle[ANGLE_BITS-1];
			theta_p[0] <= theta_s1;
			neg_p[0]   <= neg_s1;
			x2_p[0]    <= qmul(theta_s1, theta_s1);
			rs_p[0]    <= WORK_ONE;
			rc_p[0]    <= WORK_ONE;
			for (int j = 1; j < NST - 1; j++) begin
				theta_p[j] <= theta_p[j-1];
				neg_p[j]   <= neg_p[j-1];
			end
			for (int j = 1; j < NST - 3; j++)
				x2_p[j] <= x2_p[j-1];
			for (int k = 1; k <= SERIES_TERMS; k++) begin
				rs_p[2*k-1] <= qmul(x2_p[2*k-2], rs_p[2*k-2]);
				rc_p[2*k-1] <= qmul(x2_p[2*k-2], rc_p[2*k-2]);
				rs_p[2*k]   <= rs_div[k-1];
				rc_p[2*k]   <= rc_div[k-1];
			end
			neg_p[NST-1] <= neg_p[NST-2];
			rs_p[NST-1]  <= qmul(theta_p[NST-2], rs_p[NST-2]);
			rc_p[NST-1]  <= clamp_unit(rc_p[NST-2]);
		end
	end

	always_comb begin
		sc.s = neg_p[NST-1] ? -clamp_unit(rs_p[NST-1]) : clamp_unit(rs_p[NST-1]);
		sc.c = rc_p[NST-1];
	end
endmodule

[design/euler_to_quaternion.sv]
// Throughput: one item per cycle; a stall freezes the whole pipeline in place.
// The pipe depth is set by the fifteen-stage Taylor sine/cosine and three
// product and rounding stages.
// Reset (arst_n, asynchronous, low) clears the valid bits only.
// ---------------------------------------------------------------------------
// euler_to_quaternion: Z-Y-X Euler angles to unit quaternion
// Half-angle sine/cosine per axis, then two product stages and rounding.
// ---------------------------------------------------------------------------
module euler_to_quaternion (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // yaw_angle, pitch_angle, roll_angle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // quat_w, quat_x, quat_y, quat_z
);
	import e2q_pkg::*;

	localparam int DEPTH = 2 * SERIES_TERMS + 6;

	logic [DEPTH-1:0] vld_q;
	logic en;
	sincos_t scy, scp, scr;
	work_t a_s1, b_s1, e_s1, f_s1, cr_s1, sr_s1;
	work_t p_s2 [8];
	logic signed [QUAT_BITS-1:0] w_s3, x_s3, y_s3, z_s3;

	// The pipe advances unless the last stage holds an item not taken.
	assign en       = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];
	assign m_tdata  = {z_s3, y_s3, x_s3, w_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	e2q_sincos u_yaw (.clk, .en, .angle(s_tdata[15:0]), .sc(scy));
	e2q_sincos u_pitch (.clk, .en, .angle(s_tdata[31:16]), .sc(scp));
	e2q_sincos u_roll (.clk, .en, .angle(s_tdata[47:32]), .sc(scr));

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= qmul(scy.c, scp.c);
			b_s1  <= qmul(scy.s, scp.s);
			e_s1  <= qmul(scy.s, scp.c);
			f_s1  <= qmul(scy.c, scp.s);
			cr_s1 <= scr.c;
			sr_s1 <= scr.s;
			p_s2[0] <= qmul(a_s1, cr_s1);
			p_s2[1] <= qmul(b_s1, sr_s1);
			p_s2[2] <= qmul(a_s1, sr_s1);
			p_s2[3] <= qmul(b_s1, cr_s1);
			p_s2[4] <= qmul(e_s1, sr_s1);
			p_s2[5] <= qmul(f_s1, cr_s1);
			p_s2[6] <= qmul(e_s1, cr_s1);
			p_s2[7] <= qmul(f_s1, sr_s1);
			w_s3 <= to_output(p_s2[0] + p_s2[1]);
			x_s3 <= to_output(p_s2[2] - p_s2[3]);
			y_s3 <= to_output(p_s2[4] + p_s2[5]);
			z_s3 <= to_output(p_s2[6] - p_s2[7]);
		end
	end
endmodule

[design/e2q_checker.sv]
// ---------------------------------------------------------------------------
// e2q_checker: port-level checks of the Euler-to-quaternion block
// Watches handshake and result range on the top level's ports.
// ---------------------------------------------------------------------------
module e2q_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);
	// An item held at the output keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	// The input side is ready whenever the output is free or draining.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled without output backpressure");

	// The w and z components never exceed +-1.0.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384) &&
			($signed(m_tdata[15:0]) >= -16'sd16384) &&
			($signed(m_tdata[63:48]) <= 16'sd16384) &&
			($signed(m_tdata[63:48]) >= -16'sd16384))
		else $error("quaternion component out of range");

	// No result comes out of an empty pipe right after reset.
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");
endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
